### hdl/nfrt_pkg.sv
// Shared types and constants for the neighbor pending-frame table.
// Used by the controller, the datapath and the top level; no dependencies.
package nfrt_pkg;

  // Opcodes carried on the input tuser.
  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_RESOLVE = 2'd1;
  localparam logic [1:0] OP_UNREACH = 2'd2;

  // Result kinds carried on the output tuser.
  localparam logic [1:0] KIND_SEND  = 2'd0;
  localparam logic [1:0] KIND_ERROR = 2'd1;
  localparam logic [1:0] KIND_DROP  = 2'd2;

  // Fixed field widths of the stream payloads.
  localparam int ADDR_W    = 64;
  localparam int MAC_W     = 48;
  localparam int PORT_TAG_W = 8;
  localparam int IN_DATA_W  = 184;
  localparam int OUT_DATA_W = 56;

  // At most this many matches are reported per input beat.
  localparam int MAX_RESULTS = 16;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;       // capture the accepted input beat
    logic capture;     // register the match vector of the latched address
    logic write_add;   // store the latched entry
    logic emit_match;  // output the newest match and remove it
    logic emit_drop;   // output the newest entry as dropped
    logic last;        // tlast of the emitted result
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;        // table holds CAPACITY entries
    logic any_match;   // at least one match left
    logic more_match;  // another match remains besides the newest one
  } dp_status_t;

endpackage

### hdl/neighbor_pending_frame_table.sv
// Top level of the neighbor pending-frame table: stream ports, controller
// and datapath. Depends on nfrt_pkg, nfrt_ctrl and nfrt_dp.
//
//   channel  direction  handshake          payload
//   s_*      in         s_tvalid/s_tready  tuser opcode; tdata addresses, tag, MAC
//   m_*      out        m_tvalid/m_tready  tuser kind; tdata tag, MAC; tlast
//
// An add passes through the add state; a resolve or unreachable event passes
// through the match state and the emit state, which removes one reported frame
// per cycle while the output is free. An unused-opcode beat goes back to idle.
// A new beat is taken only when the previous one is finished; the output
// register lets the last result wait while the next beat is accepted.
// Output stalls hold the result loop. Reset (rst, synchronous) empties the table.
module neighbor_pending_frame_table #(
  parameter int CAPACITY  = 16,
  parameter int TAG_WIDTH = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // addr_high [63:0], addr_low [127:64], frame_tag [135:128], mac_addr [183:136]
  input  logic [nfrt_pkg::IN_DATA_W-1:0]     s_tdata,
  // opcode [1:0]
  input  logic [1:0]                         s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // out_tag [7:0], dest_mac [55:8]
  output logic [nfrt_pkg::OUT_DATA_W-1:0]    m_tdata,
  // kind [1:0]
  output logic [1:0]                         m_tuser,
  output logic                               m_tlast
);
  import nfrt_pkg::*;

  ctrl_cmd_t             cmd;
  dp_status_t            sts;
  logic [PORT_TAG_W-1:0] out_tag;
  logic [MAC_W-1:0]      out_mac;

  nfrt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_op     (s_tuser),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  nfrt_dp #(
    .CAPACITY  (CAPACITY),
    .TAG_WIDTH (TAG_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .in_op        (s_tuser),
    .in_addr_high (s_tdata[63:0]),
    .in_addr_low  (s_tdata[127:64]),
    .in_tag       (s_tdata[135:128]),
    .in_mac       (s_tdata[183:136]),
    .cmd          (cmd),
    .sts          (sts),
    .out_kind     (m_tuser),
    .out_tag      (out_tag),
    .out_mac      (out_mac),
    .out_last     (m_tlast)
  );

  assign m_tdata = {out_mac, out_tag};

  // A beat with a used opcode keeps the input closed in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready &&
    (s_tuser == OP_ADD || s_tuser == OP_RESOLVE || s_tuser == OP_UNREACH) |=> !s_tready)
    else $error("input ready stayed high after an accepted beat");

  // A drop is always the only result of its add.
  a_drop_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_DROP) |-> m_tlast)
    else $error("drop result without tlast");

  // Only send results carry a MAC.
  a_mac_only_on_send: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != KIND_SEND) |-> (m_tdata[55:8] == '0))
    else $error("non-send result carries a MAC");

  // An emit command always raises the output valid flag.
  a_emit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_match || cmd.emit_drop) |=> m_tvalid)
    else $error("emitted result not presented");

endmodule

### hdl/nfrt_ctrl.sv
// Controller state machine of the neighbor pending-frame table.
// Depends on nfrt_pkg for the opcodes and the command/status structs.
module nfrt_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [1:0]             in_op,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  nfrt_pkg::dp_status_t   sts,
  output nfrt_pkg::ctrl_cmd_t    cmd
);
  import nfrt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_MATCH,
    ST_EMIT
  } state_t;

  state_t               state;
  state_t               state_next;
  logic [RES_CNT_W-1:0] res_cnt;
  logic                 out_free;

  // The output register can take a new beat when empty or being drained.
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          case (in_op)
            OP_ADD:                 state_next = ST_ADD;
            OP_RESOLVE, OP_UNREACH: state_next = ST_MATCH;
            default:                state_next = ST_IDLE;
          endcase
        end
      end
      ST_ADD: begin
        // A full table first gives up its newest entry as a drop result.
        if (!sts.full) begin
          cmd.write_add = 1'b1;
          state_next    = ST_IDLE;
        end else if (out_free) begin
          cmd.write_add = 1'b1;
          cmd.emit_drop = 1'b1;
          cmd.last      = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_MATCH: begin
        cmd.capture = 1'b1;
        state_next  = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sts.any_match) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          cmd.emit_match = 1'b1;
          cmd.last = !sts.more_match || (res_cnt == RES_CNT_W'(MAX_RESULTS - 1));
          if (cmd.last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State, result counter and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.latch) begin
        res_cnt <= '0;
      end else if (cmd.emit_match) begin
        res_cnt <= res_cnt + 1'b1;
      end
      if (cmd.emit_match || cmd.emit_drop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### hdl/nfrt_dp.sv
// Datapath of the neighbor pending-frame table: entry store, parallel address
// compare, newest-match encoder and the output register. Depends on nfrt_pkg.
module nfrt_dp #(
  parameter int CAPACITY  = 16,
  parameter int TAG_WIDTH = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [1:0]                          in_op,
  input  logic [nfrt_pkg::ADDR_W-1:0]         in_addr_high,
  input  logic [nfrt_pkg::ADDR_W-1:0]         in_addr_low,
  input  logic [nfrt_pkg::PORT_TAG_W-1:0]     in_tag,
  input  logic [nfrt_pkg::MAC_W-1:0]          in_mac,
  input  nfrt_pkg::ctrl_cmd_t                 cmd,
  output nfrt_pkg::dp_status_t                sts,
  output logic [1:0]                          out_kind,
  output logic [nfrt_pkg::PORT_TAG_W-1:0]     out_tag,
  output logic [nfrt_pkg::MAC_W-1:0]          out_mac,
  output logic                                out_last
);
  import nfrt_pkg::*;

  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int TAG_EXT_W = (TAG_WIDTH > PORT_TAG_W) ? TAG_WIDTH : PORT_TAG_W;

  // Entries: slot 0 is the oldest, slot count-1 the newest.
  logic [ADDR_W-1:0]    key_upper [CAPACITY];
  logic [ADDR_W-1:0]    key_lower [CAPACITY];
  logic [TAG_WIDTH-1:0] entry_tag [CAPACITY];
  logic [CNT_W-1:0]     count;

  // Latched input beat.
  logic [1:0]           op_q;
  logic [ADDR_W-1:0]    hi_q;
  logic [ADDR_W-1:0]    lo_q;
  logic [TAG_WIDTH-1:0] tag_q;
  logic [MAC_W-1:0]     mac_q;

  logic [CAPACITY-1:0]  match;
  logic [CAPACITY-1:0]  cmp;
  logic [CAPACITY-1:0]  hit_onehot;
  logic [IDX_W-1:0]     hit_idx;
  logic [IDX_W-1:0]     wr_idx;
  logic                 full;
  logic [TAG_EXT_W-1:0] hit_tag_ext;
  logic [TAG_EXT_W-1:0] drop_tag_ext;

  assign full = (count == CNT_W'(CAPACITY));

  // Hold the accepted beat for the following cycles.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q  <= in_op;
      hi_q  <= in_addr_high;
      lo_q  <= in_addr_low;
      tag_q <= TAG_EXT_W'(in_tag) >> 0 == '0 ? '0 : TAG_WIDTH'(TAG_EXT_W'(in_tag));
      mac_q <= in_mac;
    end
  end

  // Full 128-bit compare against every occupied slot.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cmp[i] = (CNT_W'(i) < count) && (key_upper[i] == hi_q) && (key_lower[i] == lo_q);
    end
  end

  // The newest pending match is the highest set bit.
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign hit_onehot = {{(CAPACITY - 1){1'b0}}, 1'b1} << hit_idx;

  assign sts.full       = full;
  assign sts.any_match  = |match;
  assign sts.more_match = |(match & ~hit_onehot);

  // Match vector: loaded once, then one bit retired per result.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      match <= cmp;
    end else if (cmd.emit_match) begin
      match <= match & ~hit_onehot;
    end
  end

  // A full table overwrites its newest slot; otherwise append.
  assign wr_idx = full ? IDX_W'(CAPACITY - 1) : count[IDX_W-1:0];

  // Entry store: removal shifts newer slots down by one, add writes one slot.
  always_ff @(posedge clk) begin
    if (cmd.emit_match) begin
      for (int j = 0; j < CAPACITY - 1; j++) begin
        if (IDX_W'(j) >= hit_idx) begin
          key_upper[j] <= key_upper[j + 1];
          key_lower[j] <= key_lower[j + 1];
          entry_tag[j] <= entry_tag[j + 1];
        end
      end
    end
    if (cmd.write_add) begin
      key_upper[wr_idx] <= hi_q;
      key_lower[wr_idx] <= lo_q;
      entry_tag[wr_idx] <= tag_q;
    end
  end

  // Entry count; a drop and the add that comes with it leave it unchanged.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.emit_match) begin
      count <= count - 1'b1;
    end else if (cmd.write_add && !full) begin
      count <= count + 1'b1;
    end
  end

  assign hit_tag_ext  = TAG_EXT_W'(entry_tag[hit_idx]);
  assign drop_tag_ext = TAG_EXT_W'(entry_tag[CAPACITY - 1]);

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.emit_drop) begin
      out_kind <= KIND_DROP;
      out_tag  <= drop_tag_ext[PORT_TAG_W-1:0];
      out_mac  <= '0;
      out_last <= cmd.last;
    end else if (cmd.emit_match) begin
      out_kind <= (op_q == OP_RESOLVE) ? KIND_SEND : KIND_ERROR;
      out_tag  <= hit_tag_ext[PORT_TAG_W-1:0];
      out_mac  <= (op_q == OP_RESOLVE) ? mac_q : '0;
      out_last <= cmd.last;
    end
  end

endmodule

### bench/neighbor_pending_frame_table_test.sv
// Self-checking testbench for the neighbor pending-frame table.
// Drives add, resolve and unreachable beats, predicts every result beat in a local
// copy of the table and checks them in order. Depends on nfrt_pkg and the top level.
`timescale 1ns / 100ps

module neighbor_pending_frame_table_test;
  import nfrt_pkg::*;

  localparam int CAPACITY    = 16;
  localparam int TAG_W       = 8;
  localparam int STALL_LIMIT = 2000;
  localparam int IDLE_PCT    = 7;
  localparam int PRINT_LIMIT = 40;
  localparam int POOL_SIZE   = 5;

  // The opcode that the block has no use for.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // One frame disposition as it leaves the block.
  typedef struct packed {
    logic [1:0]       kind;
    logic [TAG_W-1:0] tag;
    logic [MAC_W-1:0] mac;
    logic             last;
  } disposition_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  // addr_high [63:0], addr_low [127:64], frame_tag [135:128], mac_addr [183:136]
  logic [IN_DATA_W-1:0]    s_tdata = '0;
  // opcode [1:0]
  logic [1:0]              s_tuser = '0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  // out_tag [7:0], dest_mac [55:8]
  logic [OUT_DATA_W-1:0]   m_tdata;
  // kind [1:0]
  logic [1:0]              m_tuser;
  logic                    m_tlast;

  // Local copy of the table, oldest entry in slot 0.
  logic [ADDR_W-1:0]       held_hi [CAPACITY];
  logic [ADDR_W-1:0]       held_lo [CAPACITY];
  logic [TAG_W-1:0]        held_tag [CAPACITY];
  int                      held_count = 0;

  // Dispositions still to come out of the block, oldest first.
  disposition_t            due_dispositions [$];

  // Neighbor addresses reused by the random part so that lookups hit.
  logic [ADDR_W-1:0]       pool_hi [POOL_SIZE];
  logic [ADDR_W-1:0]       pool_lo [POOL_SIZE];

  int                      mismatch_count = 0;
  int                      quiet_cycles = 0;
  bit                      no_idle = 1'b0;

  neighbor_pending_frame_table #(
    .CAPACITY  (CAPACITY),
    .TAG_WIDTH (TAG_W)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Prints one mismatch line, up to a limit, and counts every one.
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < PRINT_LIMIT)
      $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
               want);
    mismatch_count++;
  endtask

  // Applies one accepted beat to the local table and queues the dispositions it causes.
  function automatic void apply_table_op(input logic [1:0] op,
                                         input logic [ADDR_W-1:0] hi,
                                         input logic [ADDR_W-1:0] lo,
                                         input logic [TAG_W-1:0] tag,
                                         input logic [MAC_W-1:0] mac);
    disposition_t d;
    int produced;
    int slot;
    int j;
    produced = 0;
    if (op == OP_ADD) begin
      // A full table gives up its newest entry before taking the new one.
      if (held_count >= CAPACITY) begin
        d.kind = KIND_DROP;
        d.tag  = held_tag[held_count-1];
        d.mac  = '0;
        d.last = 1'b0;
        due_dispositions.push_back(d);
        produced++;
        held_count--;
      end
      held_hi[held_count]  = hi;
      held_lo[held_count]  = lo;
      held_tag[held_count] = tag;
      held_count++;
    end else if (op == OP_RESOLVE || op == OP_UNREACH) begin
      // Scan newest first; removal only shifts entries that were already scanned.
      slot = held_count;
      while (slot > 0 && produced < MAX_RESULTS) begin
        slot--;
        if (held_hi[slot] == hi && held_lo[slot] == lo) begin
          d.kind = (op == OP_RESOLVE) ? KIND_SEND : KIND_ERROR;
          d.tag  = held_tag[slot];
          d.mac  = (op == OP_RESOLVE) ? mac : '0;
          d.last = 1'b0;
          due_dispositions.push_back(d);
          produced++;
          for (j = slot; j + 1 < held_count; j++) begin
            held_hi[j]  = held_hi[j+1];
            held_lo[j]  = held_lo[j+1];
            held_tag[j] = held_tag[j+1];
          end
          held_count--;
        end
      end
    end
    // The final disposition of the beat carries tlast.
    if (produced > 0) begin
      d = due_dispositions.pop_back();
      d.last = 1'b1;
      due_dispositions.push_back(d);
    end
  endfunction

  // Offers one beat, with random idle cycles first, and predicts it once accepted.
  // tvalid stays high afterwards; the next call or the end of the run lowers it.
  task automatic send_beat(input logic [1:0] op, input logic [ADDR_W-1:0] hi,
                           input logic [ADDR_W-1:0] lo, input logic [TAG_W-1:0] tag,
                           input logic [MAC_W-1:0] mac);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {mac, tag, lo, hi};
    do
      @(posedge clk);
    while (!s_tready);
    apply_table_op(op, hi, lo, tag, mac);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Fills the table with one address, overflows it, then clears it by resolve
  // and by unreachable. Also covers the field extremes.
  task automatic test_full_table();
    int i;
    for (i = 0; i < CAPACITY; i++)
      send_beat(OP_ADD, '1, '1, TAG_W'(i * 17), rand64());
    // The table is full: the newest frame (tag all ones) is dropped.
    send_beat(OP_ADD, '0, '0, 8'h5A, rand64());
    // Every remaining all-ones entry goes out, newest first.
    send_beat(OP_RESOLVE, '1, '1, 8'hFF, '1);
    // Unreachable reports the entry with a zero MAC, whatever the beat carries.
    send_beat(OP_UNREACH, '0, '0, 8'h00, '1);
  endtask

  // Lookups that hit nothing give no result.
  task automatic test_no_match();
    send_beat(OP_RESOLVE, rand64(), rand64(), 8'h00, rand64());
    send_beat(OP_UNREACH, rand64(), rand64(), 8'hFF, rand64());
  endtask

  // Addresses one bit apart in either half must not match; the unused opcode
  // must leave the table alone.
  task automatic test_address_compare();
    logic [ADDR_W-1:0] hi;
    logic [ADDR_W-1:0] lo;
    hi = rand64();
    lo = rand64();
    send_beat(OP_ADD, hi, lo, 8'h11, rand64());
    send_beat(OP_ADD, hi ^ 64'h8000_0000_0000_0000, lo, 8'h22, rand64());
    send_beat(OP_ADD, hi, lo ^ 64'h1, 8'h33, rand64());
    send_beat(OP_UNUSED, hi, lo, 8'h44, rand64());
    send_beat(OP_RESOLVE, hi, lo, 8'h55, '0);
    send_beat(OP_UNREACH, hi ^ 64'h8000_0000_0000_0000, lo, 8'h66, rand64());
  endtask

  // Random traffic, mostly on a few neighbors so that frames pile up and get
  // resolved, dropped or reported. Beats with the unused opcode are not counted.
  task automatic test_random_traffic(input int beats, input bit steady);
    int sent;
    int pick;
    int roll;
    logic [1:0] op;
    logic [ADDR_W-1:0] hi;
    logic [ADDR_W-1:0] lo;
    sent = 0;
    no_idle = steady;
    while (sent < beats) begin
      roll = $urandom_range(0, 99);
      if (roll < 3)
        op = OP_UNUSED;
      else if (roll < 55)
        op = OP_ADD;
      else if (roll < 78)
        op = OP_RESOLVE;
      else
        op = OP_UNREACH;
      if ($urandom_range(0, 99) < 88) begin
        pick = $urandom_range(0, POOL_SIZE - 1);
        hi = pool_hi[pick];
        lo = pool_lo[pick];
      end else begin
        hi = rand64();
        lo = rand64();
      end
      send_beat(op, hi, lo, TAG_W'($urandom_range(0, 255)), rand64());
      if (op != OP_UNUSED)
        sent++;
    end
    no_idle = 1'b0;
  endtask

  // Random backpressure on the result side.
  always @(posedge clk)
    m_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);

  // Checks each result beat against the oldest predicted disposition.
  always @(posedge clk) begin
    disposition_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (due_dispositions.size() == 0) begin
        report_mismatch("result beat with nothing pending", {m_tuser, m_tdata}, '0);
      end else begin
        want = due_dispositions.pop_front();
        if (m_tuser != want.kind)
          report_mismatch("kind", m_tuser, want.kind);
        if (m_tdata[TAG_W-1:0] != want.tag)
          report_mismatch("out_tag", m_tdata[TAG_W-1:0], want.tag);
        if (m_tdata[TAG_W +: MAC_W] != want.mac)
          report_mismatch("dest_mac", m_tdata[TAG_W +: MAC_W], want.mac);
        if (m_tlast != want.last)
          report_mismatch("tlast", m_tlast, want.last);
      end
    end
  end

  // Ends the run when neither side moves a beat for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL neighbor_pending_frame_table");
        $finish;
      end
    end
  end

  // Test sequence.
  initial begin
    int k;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_full_table();
    test_no_match();
    test_address_compare();

    // Neighbor pool: some addresses differ from another in one bit of one half.
    for (k = 0; k < POOL_SIZE; k++) begin
      pool_hi[k] = rand64();
      pool_lo[k] = rand64();
    end
    pool_hi[1] = pool_hi[0];
    pool_lo[1] = pool_lo[0] ^ (64'h1 << $urandom_range(0, 63));
    pool_hi[2] = pool_hi[0] ^ (64'h1 << $urandom_range(0, 63));
    pool_lo[2] = pool_lo[0];

    test_random_traffic(40, 1'b1);
    test_random_traffic(103, 1'b0);
    s_tvalid <= 1'b0;

    // Drain, then keep watching for anything unexpected.
    while (due_dispositions.size() != 0)
      @(posedge clk);
    repeat (30) @(posedge clk);

    if (mismatch_count == 0)
      $display("PASS neighbor_pending_frame_table");
    else
      $display("FAIL neighbor_pending_frame_table");
    $finish;
  end

endmodule
